@@ sv/tvp_pkg.sv @@
// Shared types and constants for the TSDF voxel projection core.
// No dependencies; every other file but tvp_fifo imports this package.
package tvp_pkg;

  // Projection sums: a signed Q16.16 coefficient times a 7-bit index, four terms.
  localparam int PROJ_W     = 42;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_LO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW0_HI = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW1_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW2_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TRUNC   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE   = 3'd7;

  localparam logic [31:0] TRUNC_RESET = 32'h0001_0000;

  // Request actions
  localparam logic ACT_DEPTH = 1'b0;
  localparam logic ACT_VOXEL = 1'b1;

  // Result classes
  localparam logic [1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [1:0] CLS_INSIDE  = 2'd1;
  localparam logic [1:0] CLS_FRONT   = 2'd2;

  localparam logic signed [15:0] TSDF_POS_ONE = 16'sd16384;
  localparam logic signed [15:0] TSDF_NEG_ONE = -16'sd16384;

  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

  // 12 coefficients, row-major: row r coefficient n at index r*4+n
  typedef logic [11:0][31:0] coef_set_t;

  typedef struct packed {
    logic        action;
    logic [18:0] pixel_index;
    logic [31:0] depth_value;
    logic [6:0]  voxel_i;
    logic [6:0]  voxel_j;
    logic [6:0]  voxel_k;
  } req_t;

  typedef struct packed {
    logic signed [15:0] tsdf_value;
    logic [1:0]         voxel_class;
  } result_t;

  // Classified request handed from the front end to the back end
  typedef struct packed {
    logic                     action;
    logic                     off_grid;
    logic [18:0]              pixel_index;
    logic [31:0]              depth_value;
    logic signed [PROJ_W-1:0] q0;
    logic signed [PROJ_W-1:0] q1;
    logic signed [PROJ_W-1:0] z;
  } work_t;

  typedef struct packed {
    logic [31:0] trunc_distance;
    logic [31:0] image_size;
  } back_cfg_t;

endpackage

@@ sv/tvp_fifo.sv @@
// Small register-based queue, generic over the item type.
// No dependencies.
module tvp_fifo #(
  parameter type item_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output item_t dout
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("queue count above depth");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == CW'(DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ sv/tvp_front.sv @@
// Front end: accepts requests, flags off-grid voxels, projects through the
// 3x4 matrix in two stages. Depends on tvp_pkg.
module tvp_front #(
  parameter int GRID_SIZE = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  tvp_pkg::req_t      req,
  input  tvp_pkg::coef_set_t coefs,
  output logic               wq_push,
  input  logic               wq_full,
  output tvp_pkg::work_t     wq_item
);

  import tvp_pkg::*;

  localparam int PROD_W = 40;

  logic                     s1_valid;
  logic                     s2_valid;
  logic                     adv;
  logic                     s1_take;
  req_t                     s1_req;
  logic                     s1_off;
  logic signed [PROD_W-1:0] prod [3][3];
  logic signed [31:0]       konst [3];
  logic [7:0]               idx [3];
  logic signed [PROJ_W-1:0] qsum [3];
  work_t                    s2_item;

  assign adv     = !s2_valid || !wq_full;
  assign s1_take = !s1_valid || adv;
  assign full    = !s1_take;
  assign wq_push = s2_valid;
  assign wq_item = s2_item;

  assign idx[0] = {1'b0, req.voxel_i};
  assign idx[1] = {1'b0, req.voxel_j};
  assign idx[2] = {1'b0, req.voxel_k};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_valid <= push;
      end
      if (adv) begin
        s2_valid <= s1_valid;
      end
    end
  end

  // stage 1: the nine coefficient products
  always_ff @(posedge clk) begin
    if (s1_take && push) begin
      s1_req <= req;
      s1_off <= (32'(req.voxel_i) >= GRID_SIZE) || (32'(req.voxel_j) >= GRID_SIZE) ||
                (32'(req.voxel_k) >= GRID_SIZE);
      for (int r = 0; r < 3; r++) begin
        for (int n = 0; n < 3; n++) begin
          prod[r][n] <= $signed(coefs[r*4+n]) * $signed(idx[n]);
        end
        konst[r] <= $signed(coefs[r*4+3]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      qsum[r] = PROJ_W'(prod[r][0]) + PROJ_W'(prod[r][1]) + PROJ_W'(prod[r][2]) +
                PROJ_W'(konst[r]);
    end
  end

  // stage 2: row sums
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_item.action      <= s1_req.action;
      s2_item.off_grid    <= s1_off;
      s2_item.pixel_index <= s1_req.pixel_index;
      s2_item.depth_value <= s1_req.depth_value;
      s2_item.q0          <= qsum[0];
      s2_item.q1          <= qsum[1];
      s2_item.z           <= qsum[2];
    end
  end

endmodule

@@ sv/tvp_back.sv @@
// Back end: depth store, pixel divide, bilinear fetch and TSDF evaluation.
// Depends on tvp_pkg.
module tvp_back #(
  parameter int PIXEL_WORDS = 524288
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wq_empty,
  output logic               wq_pop,
  input  tvp_pkg::work_t     wq_item,
  input  tvp_pkg::back_cfg_t cfg,
  input  logic               rq_full,
  output logic               rq_push,
  output tvp_pkg::result_t   rq_item
);

  import tvp_pkg::*;

  localparam int AW         = $clog2(PIXEL_WORDS);
  localparam int DIV_STEPS  = 32;
  localparam int FRAC_STEPS = 15;
  localparam int SW         = $clog2(DIV_STEPS + 1);
  localparam int DW         = PROJ_W + 1;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_PDIV  = 9'b000000010,
    S_RANGE = 9'b000000100,
    S_READ  = 9'b000001000,
    S_DEPTH = 9'b000010000,
    S_DIFF  = 9'b000100000,
    S_BAND  = 9'b001000000,
    S_FDIV  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  state_t                   state;
  logic [31:0]              mem [PIXEL_WORDS];
  logic [31:0]              rd_data;
  logic                     mem_we;
  logic [AW-1:0]            mem_raddr;
  logic [31:0]              raddr_full;

  logic signed [PROJ_W-1:0] z_r;
  logic [PROJ_W-1:0]        rem_u, rem_v, t_u, t_v;
  logic                     ge_u, ge_v;
  logic [31:0]              pu, pv;
  logic [SW-1:0]            step;
  logic [15:0]              img_w, img_h, u, v;
  logic [16:0]              wu0, wv0, du, dv;
  logic [31:0]              base;
  logic [32:0]              w [4];
  logic [2:0]               rd_cnt;
  logic [1:0]               widx;
  logic [63:0]              prod, acc;
  logic [64:0]              rounded;
  logic [32:0]              depth_r;
  logic [DW-1:0]            absd, tr_ext;
  logic                     neg, d0_zero;
  logic [46:0]              num;
  logic [31:0]              frem;
  logic [32:0]              t_f;
  logic                     ge_f;
  logic [14:0]              fq, fq_next;
  logic signed [15:0]       res_val;
  logic [1:0]               res_cls;
  logic                     bad_vox;

  assign wq_pop  = (state == S_IDLE) && !wq_empty;
  assign mem_we  = wq_pop && (wq_item.action == ACT_DEPTH) &&
                   (32'(wq_item.pixel_index) < PIXEL_WORDS);
  assign rq_push = (state == S_EMIT) && !rq_full;
  assign rq_item.tsdf_value  = res_val;
  assign rq_item.voxel_class = res_cls;

  assign img_w = cfg.image_size[31:16];
  assign img_h = cfg.image_size[15:0];
  assign u     = pu[31:16];
  assign v     = pv[31:16];
  assign du    = {1'b0, pu[15:0]};
  assign dv    = {1'b0, pv[15:0]};
  assign wu0   = 17'h10000 - du;
  assign wv0   = 17'h10000 - dv;

  // negative or oversized coordinates fall outside the image anyway
  assign bad_vox = wq_item.off_grid || wq_item.z[PROJ_W-1] || (wq_item.z == '0) ||
                   wq_item.q0[PROJ_W-1] || wq_item.q1[PROJ_W-1] ||
                   ($unsigned(wq_item.q0[PROJ_W-1:16]) >= $unsigned(wq_item.z)) ||
                   ($unsigned(wq_item.q1[PROJ_W-1:16]) >= $unsigned(wq_item.z));

  // restoring divide steps
  assign t_u  = {rem_u[PROJ_W-2:0], pu[31]};
  assign t_v  = {rem_v[PROJ_W-2:0], pv[31]};
  assign ge_u = t_u >= $unsigned(z_r);
  assign ge_v = t_v >= $unsigned(z_r);
  assign t_f  = {frem, fq[14]};
  assign ge_f = t_f >= {1'b0, cfg.trunc_distance};
  assign fq_next = {fq[13:0], ge_f};

  assign widx    = 2'(rd_cnt - 3'd1);
  assign rounded = {1'b0, acc} + 65'h0_8000_0000;
  assign tr_ext  = DW'(cfg.trunc_distance);
  assign num     = {1'b0, absd[31:0], 14'b0} + 47'(cfg.trunc_distance[31:1]);

  always_comb begin
    unique case (rd_cnt[1:0])
      2'd0:    raddr_full = base;
      2'd1:    raddr_full = base + 32'd1;
      2'd2:    raddr_full = base + {16'b0, img_w};
      default: raddr_full = base + {16'b0, img_w} + 32'd1;
    endcase
  end
  assign mem_raddr = raddr_full[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(wq_item.pixel_index)] <= wq_item.depth_value;
    end
    rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (wq_pop && wq_item.action == ACT_VOXEL) begin
            if (bad_vox) begin
              state <= S_EMIT;
            end else begin
              state <= S_PDIV;
            end
          end
        end
        S_PDIV: begin
          if (step == SW'(DIV_STEPS - 1)) begin
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          if (img_w < 16'd2 || img_h < 16'd2 || u == '0 || v == '0 ||
              u >= img_w - 16'd1 || v >= img_h - 16'd1) begin
            state <= S_EMIT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (rd_cnt == 3'd5) begin
            state <= S_DEPTH;
          end
        end
        S_DEPTH: state <= S_DIFF;
        S_DIFF:  state <= S_BAND;
        S_BAND: begin
          if (!d0_zero && absd < tr_ext) begin
            state <= S_FDIV;
          end else begin
            state <= S_EMIT;
          end
        end
        S_FDIV: begin
          if (step == SW'(FRAC_STEPS - 1)) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (!rq_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        res_val <= TSDF_NEG_ONE;
        res_cls <= CLS_OUTSIDE;
        step    <= '0;
        z_r     <= wq_item.z;
        rem_u   <= PROJ_W'(wq_item.q0[PROJ_W-1:16]);
        rem_v   <= PROJ_W'(wq_item.q1[PROJ_W-1:16]);
        pu      <= {wq_item.q0[15:0], 16'b0};
        pv      <= {wq_item.q1[15:0], 16'b0};
      end
      S_PDIV: begin
        step  <= step + 1'b1;
        rem_u <= ge_u ? t_u - $unsigned(z_r) : t_u;
        rem_v <= ge_v ? t_v - $unsigned(z_r) : t_v;
        pu    <= {pu[30:0], ge_u};
        pv    <= {pv[30:0], ge_v};
      end
      S_RANGE: begin
        base   <= {16'b0, v} * {16'b0, img_w} + {16'b0, u};
        w[0]   <= {16'b0, wu0} * {16'b0, wv0};
        w[1]   <= {16'b0, du} * {16'b0, wv0};
        w[2]   <= {16'b0, wu0} * {16'b0, dv};
        w[3]   <= {16'b0, du} * {16'b0, dv};
        rd_cnt <= '0;
        acc    <= '0;
      end
      S_READ: begin
        rd_cnt <= rd_cnt + 1'b1;
        if (rd_cnt != 3'd0 && rd_cnt != 3'd5) begin
          prod <= {32'b0, rd_data} * {31'b0, w[widx]};
        end
        if (rd_cnt == 3'd1) begin
          d0_zero <= (rd_data == '0);
        end
        if (rd_cnt >= 3'd2) begin
          acc <= acc + prod;
        end
      end
      S_DEPTH: depth_r <= rounded[64:32];
      S_DIFF: begin
        absd <= ($signed({{(DW-33){1'b0}}, depth_r}) < DW'(z_r)) ?
                DW'(z_r) - {{(DW-33){1'b0}}, depth_r} :
                {{(DW-33){1'b0}}, depth_r} - DW'(z_r);
        neg  <= $signed({{(DW-33){1'b0}}, depth_r}) < DW'(z_r);
      end
      S_BAND: begin
        step <= '0;
        frem <= num[46:15];
        fq   <= num[14:0];
        if (!d0_zero && !(absd < tr_ext) && !neg && absd > tr_ext) begin
          res_val <= TSDF_POS_ONE;
          res_cls <= CLS_FRONT;
        end
      end
      S_FDIV: begin
        step <= step + 1'b1;
        frem <= ge_f ? 32'(t_f - {1'b0, cfg.trunc_distance}) : t_f[31:0];
        fq   <= fq_next;
        if (step == SW'(FRAC_STEPS - 1)) begin
          res_val <= neg ? -$signed({1'b0, fq_next}) : $signed({1'b0, fq_next});
          res_cls <= CLS_INSIDE;
        end
      end
      S_EMIT: ;
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_front_one: assert property (@(posedge clk) disable iff (rst)
    (rq_push && rq_item.voxel_class == CLS_FRONT) |-> rq_item.tsdf_value == TSDF_POS_ONE)
    else $error("front-of-band result not +1");
  a_inside_range: assert property (@(posedge clk) disable iff (rst)
    (rq_push && rq_item.voxel_class == CLS_INSIDE) |->
      (rq_item.tsdf_value <= TSDF_POS_ONE && rq_item.tsdf_value >= TSDF_NEG_ONE))
    else $error("inside-band result out of range");
  a_frem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_FDIV) |-> frem < cfg.trunc_distance)
    else $error("band divider remainder not below divisor");
`endif

endmodule

@@ sv/tsdf_voxel_projection_core.sv @@
// Top level of the TSDF voxel projection core: configuration registers,
// front end, work queue, back end and result queue. Depends on tvp_pkg.
//
//   channel   handshake          payload                 direction
//   request   push / full        req (tvp_pkg::req_t)    in
//   result    pop / empty        result (result_t)       out
//   config    cfg_write          cfg_index, cfg_data     in
//
// Depth writes retire at one per cycle while the back end is idle. A voxel
// rejected before the divide (off the grid, z not positive, or a coordinate
// clearly off the image) goes straight to the result; any other voxel passes
// through a 32-step pixel-coordinate divider, four reads of the depth memory,
// and a 15-step divider for an inside-band value.
// The front end projects in two stages and keeps accepting while the work
// queue has room; full rises only when that queue and the pipe are backed up.
// Reset (rst, synchronous) resets control and registers; the depth store is
// not cleared and must be written before it is read. Results wait in a
// two-entry queue, so a stalled pop does not stall request intake at once.
module tsdf_voxel_projection_core #(
  parameter int GRID_SIZE   = 128,
  parameter int PIXEL_WORDS = 524288
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  tvp_pkg::req_t                         req,
  input  logic                                  pop,
  output logic                                  empty,
  output tvp_pkg::result_t                      result,
  input  logic                                  cfg_write,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tvp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import tvp_pkg::*;

  coef_set_t   coefs;
  logic [31:0] trunc_distance;
  logic [31:0] image_size;
  back_cfg_t   back_cfg;

  logic        wq_push, wq_full, wq_empty, wq_pop;
  work_t       wq_in, wq_out;
  logic        rq_push, rq_full;
  result_t     rq_in;

  // each projection register carries two coefficients
  always_ff @(posedge clk) begin
    if (rst) begin
      coefs          <= '0;
      trunc_distance <= TRUNC_RESET;
      image_size     <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_ROW0_LO: begin coefs[0]  <= cfg_data[31:0]; coefs[1]  <= cfg_data[63:32]; end
        CFG_ROW0_HI: begin coefs[2]  <= cfg_data[31:0]; coefs[3]  <= cfg_data[63:32]; end
        CFG_ROW1_LO: begin coefs[4]  <= cfg_data[31:0]; coefs[5]  <= cfg_data[63:32]; end
        CFG_ROW1_HI: begin coefs[6]  <= cfg_data[31:0]; coefs[7]  <= cfg_data[63:32]; end
        CFG_ROW2_LO: begin coefs[8]  <= cfg_data[31:0]; coefs[9]  <= cfg_data[63:32]; end
        CFG_ROW2_HI: begin coefs[10] <= cfg_data[31:0]; coefs[11] <= cfg_data[63:32]; end
        CFG_TRUNC:   trunc_distance <= cfg_data[31:0];
        CFG_IMAGE:   image_size     <= cfg_data[31:0];
        default:     ;
      endcase
    end
  end

  assign back_cfg.trunc_distance = trunc_distance;
  assign back_cfg.image_size     = image_size;

  tvp_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .req     (req),
    .coefs   (coefs),
    .wq_push (wq_push),
    .wq_full (wq_full),
    .wq_item (wq_in)
  );

  tvp_fifo #(.item_t(work_t), .DEPTH(QUEUE_DEPTH)) u_work_q (
    .clk   (clk),
    .rst   (rst),
    .push  (wq_push),
    .din   (wq_in),
    .full  (wq_full),
    .pop   (wq_pop),
    .empty (wq_empty),
    .dout  (wq_out)
  );

  tvp_back #(.PIXEL_WORDS(PIXEL_WORDS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .wq_empty (wq_empty),
    .wq_pop   (wq_pop),
    .wq_item  (wq_out),
    .cfg      (back_cfg),
    .rq_full  (rq_full),
    .rq_push  (rq_push),
    .rq_item  (rq_in)
  );

  tvp_fifo #(.item_t(result_t), .DEPTH(OUT_DEPTH)) u_result_q (
    .clk   (clk),
    .rst   (rst),
    .push  (rq_push),
    .din   (rq_in),
    .full  (rq_full),
    .pop   (pop),
    .empty (empty),
    .dout  (result)
  );

endmodule

@@ tb/tvp_checker.sv @@
// Result checker for the TSDF voxel projection core: watches the request,
// result and config channels, predicts each voxel answer and compares.
// Depends on tvp_pkg.
module tvp_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  logic                            full,
  input  tvp_pkg::req_t                   req,
  input  logic                            pop,
  input  logic                            empty,
  input  tvp_pkg::result_t                result,
  input  logic                            cfg_write,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tvp_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              fails,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tvp_pkg::*;

  logic [63:0] proj_q [6];
  logic [31:0] trunc_q;
  logic [31:0] image_q;
  logic [31:0] depth_mem [int];
  result_t     tsdf_expected [$];

  function automatic longint coef(int r, int n);
    logic [63:0] w;
    w = proj_q[2 * r + n / 2];
    return (n % 2) ? longint'(signed'(w[63:32])) : longint'(signed'(w[31:0]));
  endfunction

  function automatic longint row_sum(int r, logic [6:0] i, logic [6:0] j, logic [6:0] k);
    return coef(r, 0) * longint'(i) + coef(r, 1) * longint'(j) +
           coef(r, 2) * longint'(k) + coef(r, 3);
  endfunction

  // floor division, d > 0
  function automatic longint fdiv(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic logic [31:0] depth_at(longint a);
    int ix;
    ix = int'(a[18:0]);
    return depth_mem.exists(ix) ? depth_mem[ix] : 32'd0;
  endfunction

  // Pixel lookup: returns 1 when the voxel lands strictly inside the image.
  // Also used by the stimulus to know which depth words a voxel will read.
  function automatic bit locate(input logic [6:0] i, input logic [6:0] j,
                                input logic [6:0] k, output longint z,
                                output longint pu, output longint pv,
                                output longint base);
    longint q0, q1, u, v, w, h;
    q0 = row_sum(0, i, j, k);
    q1 = row_sum(1, i, j, k);
    z = row_sum(2, i, j, k);
    pu = 0;
    pv = 0;
    base = 0;
    if (z <= 0) return 0;
    pu = fdiv(q0 * 65536, z);
    pv = fdiv(q1 * 65536, z);
    u = pu >>> 16;
    v = pv >>> 16;
    w = longint'(image_q[31:16]);
    h = longint'(image_q[15:0]);
    if (u <= 0 || u >= w - 1 || v <= 0 || v >= h - 1) return 0;
    base = v * w + u;
    return 1;
  endfunction

  function automatic result_t tsdf_of(req_t r);
    longint z, pu, pv, base, w, depth, diff, tr, num, f;
    longint unsigned du, dv, wu0, wv0, sum;
    result_t res;
    res.tsdf_value = TSDF_NEG_ONE;
    res.voxel_class = CLS_OUTSIDE;
    if (!locate(r.voxel_i, r.voxel_j, r.voxel_k, z, pu, pv, base)) return res;
    if (depth_at(base) == 32'd0) return res;
    w = longint'(image_q[31:16]);
    du = pu - ((pu >>> 16) * 65536);
    dv = pv - ((pv >>> 16) * 65536);
    wu0 = 65536 - du;
    wv0 = 65536 - dv;
    sum = depth_at(base) * (wu0 * wv0) + depth_at(base + 1) * (du * wv0) +
          depth_at(base + w) * (wu0 * dv) + depth_at(base + w + 1) * (du * dv);
    depth = longint'((sum + 64'h8000_0000) >> 32);
    diff = depth - z;
    tr = longint'(trunc_q);
    if (diff < tr && diff > -tr) begin
      num = diff * 16384;
      if (num >= 0) f = (num + tr / 2) / tr;
      else f = -((-num + tr / 2) / tr);
      res.tsdf_value = f[15:0];
      res.voxel_class = CLS_INSIDE;
    end else if (diff > tr) begin
      res.tsdf_value = TSDF_POS_ONE;
      res.voxel_class = CLS_FRONT;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t exp_r;
    if (rst) begin
      foreach (proj_q[n]) proj_q[n] = '0;
      trunc_q = TRUNC_RESET;
      image_q = '0;
      fails = 0;
      tsdf_expected.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_TRUNC: trunc_q = cfg_data[31:0];
          CFG_IMAGE: image_q = cfg_data[31:0];
          default:   proj_q[cfg_index] = cfg_data;
        endcase
      end
      if (push && !full) begin
        if (req.action == ACT_VOXEL) tsdf_expected = {tsdf_expected, tsdf_of(req)};
        else depth_mem[int'(req.pixel_index)] = req.depth_value;
      end
      if (pop && !empty) begin
        if (tsdf_expected.size() == 0) begin
          $display("%0t unexpected result: got %0d/%0d", $time,
                   result.tsdf_value, result.voxel_class);
          fails++;
        end else begin
          exp_r = tsdf_expected.pop_front();
          if (result.tsdf_value !== exp_r.tsdf_value ||
              result.voxel_class !== exp_r.voxel_class) begin
            $display("%0t result mismatch: expected %0d/%0d, got %0d/%0d", $time,
                     exp_r.tsdf_value, exp_r.voxel_class,
                     result.tsdf_value, result.voxel_class);
            fails++;
          end
        end
      end
    end
    pending = tsdf_expected.size();
  end

endmodule

@@ tb/tb.sv @@
// Testbench top for the TSDF voxel projection core: clock, reset, request
// and config stimulus, result pop pacing, watchdog and verdict.
// Depends on tvp_pkg, tvp_checker and the core RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tvp_pkg::*;

  localparam int IDLE_LIMIT = 5000;  // cycles with no handshake at all
  localparam int SETTLE     = 80;    // exceeds the worst voxel latency

  logic                  clk;
  logic                  rst;
  logic                  push;
  logic                  full;
  req_t                  req;
  logic                  pop;
  logic                  empty;
  result_t               result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fails;
  int                    pending;

  // pacing knobs, percent of cycles idle / stalled
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 0;
  bit hold_seen = 0;

  // shadow of the register file and of which depth words hold data
  logic [63:0] regs [8];
  bit          depth_written [0:524287];
  int          idle_cycles = 0;

  tsdf_voxel_projection_core uut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .pop(pop), .empty(empty), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tvp_checker chk (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .pop(pop), .empty(empty), .result(result),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: any accepted request, result or register write resets it.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || cfg_write) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[tsdf_voxel_projection_core] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side. One long hold-off on request lets the core back up
  // until full rises; otherwise pop follows the stall percentage.
  initial begin
    pop = 0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_seen) begin
        hold_seen = 1;
        pop = 0;
        repeat (400) @(negedge clk);
      end else begin
        pop = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // One request; push stays high after acceptance until the next call
  // decides, so back-to-back requests never drop push for a step.
  task automatic send_request(req_t r);
    @(negedge clk);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push = 0;
      @(negedge clk);
    end
    push = 1;
    req = r;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic write_depth(logic [18:0] addr, logic [31:0] val);
    req_t r;
    r = req_t'({$urandom, $urandom, $urandom});
    r.action = ACT_DEPTH;
    r.pixel_index = addr;
    r.depth_value = val;
    send_request(r);
    depth_written[addr] = 1;
  endtask

  // Depth near z so that all three bands come up, with some holes.
  function automatic logic [31:0] depth_near(longint z);
    longint sp, d;
    sp = longint'(regs[CFG_TRUNC][31:0]);
    if (sp > 64'h2000_0000) sp = 64'h2000_0000;
    if (sp < 1000) sp = 1000;
    case ($urandom_range(19))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: d = z - 2 * sp + longint'($urandom_range(32'(4 * sp)));
    endcase
    if (d < 1) d = 1;
    if (d > 64'hFFFF_FFFF) d = 64'hFFFF_FFFF;
    return d[31:0];
  endfunction

  // Voxel request; any neighbour word it will read gets written first.
  task automatic send_voxel(logic [6:0] i, logic [6:0] j, logic [6:0] k);
    req_t r;
    longint z, pu, pv, base, w;
    logic [18:0] a [4];
    if (chk.locate(i, j, k, z, pu, pv, base)) begin
      w = longint'(regs[CFG_IMAGE][31:16]);
      a[0] = base[18:0];
      a[1] = 19'(base + 1);
      a[2] = 19'(base + w);
      a[3] = 19'(base + w + 1);
      foreach (a[n]) if (!depth_written[a[n]]) write_depth(a[n], depth_near(z));
    end
    r = req_t'({$urandom, $urandom, $urandom});
    r.action = ACT_VOXEL;
    r.voxel_i = i;
    r.voxel_j = j;
    r.voxel_k = k;
    send_request(r);
  endtask

  // Drop push, wait for every result, then let trailing depth writes retire.
  task automatic settle();
    @(negedge clk);
    push = 0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_config();
    for (int n = 0; n < 8; n++) begin
      @(negedge clk);
      cfg_write = 1;
      cfg_index = n[CFG_IDX_W-1:0];
      cfg_data = regs[n];
    end
    @(negedge clk);
    cfg_write = 0;
  endtask

  function automatic logic [31:0] rnd_fix(int lo, int hi);
    return 32'(int'($urandom_range(hi - lo)) + lo);
  endfunction

  // Plausible camera: u grows with i, v with j, z grows with k and varies slowly.
  // scale stretches u and v so larger images get covered.
  task automatic random_config(int scale, logic [31:0] image);
    regs[CFG_ROW0_LO] = {rnd_fix(-3000, 3000), rnd_fix(6000 * scale, 65536 * scale)};
    regs[CFG_ROW0_HI] = {rnd_fix(32768, 196608 * scale), rnd_fix(-3000, 3000)};
    regs[CFG_ROW1_LO] = {rnd_fix(6000 * scale, 65536 * scale), rnd_fix(-3000, 3000)};
    regs[CFG_ROW1_HI] = {rnd_fix(32768, 196608 * scale), rnd_fix(-3000, 3000)};
    regs[CFG_ROW2_LO] = {rnd_fix(-500, 500), rnd_fix(-500, 500)};
    regs[CFG_ROW2_HI] = {rnd_fix(65536, 196608), rnd_fix(0, 8000)};
    regs[CFG_TRUNC] = {32'd0, rnd_fix(1000, 200000)};
    regs[CFG_IMAGE] = {32'd0, image};
    load_config();
  endtask

  task automatic random_traffic(int count, int reach);
    repeat (count) begin
      if ($urandom_range(99) < 20) begin
        write_depth(19'($urandom), ($urandom_range(9) == 0) ? 32'd0 : $urandom);
      end else if ($urandom_range(9) == 0) begin
        send_voxel(7'($urandom), 7'($urandom), 7'($urandom));
      end else begin
        send_voxel(7'($urandom_range(reach)), 7'($urandom_range(reach)),
                   7'($urandom_range(reach)));
      end
    end
    settle();
  endtask

  function automatic logic [31:0] extreme_word();
    case ($urandom_range(3))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  initial begin
    push = 0;
    req = '0;
    cfg_write = 0;
    cfg_index = '0;
    cfg_data = '0;
    rst = 1;
    foreach (regs[n]) regs[n] = '0;
    regs[CFG_TRUNC] = {32'd0, TRUNC_RESET};
    repeat (10) @(negedge clk);
    rst = 0;

    // Reset values: zero image and zero projection, every voxel unseen.
    write_depth(19'd0, 32'd0);
    write_depth(19'h7FFFF, 32'hFFFF_FFFF);
    send_voxel(7'd0, 7'd0, 7'd0);
    send_voxel(7'd127, 7'd127, 7'd127);
    settle();

    // Directed: u = i/2 + 1, v = j/2 + 1, z = 1.0, 16x12 image.
    // Voxel (0,0,0) lands on pixel 17 with no fraction.
    regs[CFG_ROW0_LO] = {32'h0000_0000, 32'h0000_8000};
    regs[CFG_ROW0_HI] = {32'h0001_0000, 32'h0000_0000};
    regs[CFG_ROW1_LO] = {32'h0000_8000, 32'h0000_0000};
    regs[CFG_ROW1_HI] = {32'h0001_0000, 32'h0000_0000};
    regs[CFG_ROW2_LO] = 64'd0;
    regs[CFG_ROW2_HI] = {32'h0001_0000, 32'h0000_0000};
    regs[CFG_TRUNC] = 64'h0001_0000;
    regs[CFG_IMAGE] = 64'h0010_000C;
    load_config();
    write_depth(19'd17, 32'd131072);          // diff exactly trunc
    send_voxel(7'd0, 7'd0, 7'd0);
    write_depth(19'd17, 32'd131073);          // just in front of band
    send_voxel(7'd0, 7'd0, 7'd0);
    write_depth(19'd17, 32'd95536);           // inside, positive
    send_voxel(7'd0, 7'd0, 7'd0);
    write_depth(19'd17, 32'd1);               // inside, near -1
    send_voxel(7'd0, 7'd0, 7'd0);
    write_depth(19'd17, 32'd0);               // no depth at pixel
    send_voxel(7'd0, 7'd0, 7'd0);
    write_depth(19'd17, 32'd70000);
    send_voxel(7'd1, 7'd1, 7'd0);             // bilinear, half-pixel weights
    send_voxel(7'd28, 7'd0, 7'd0);            // u at right edge
    send_voxel(7'd0, 7'd22, 7'd0);            // v past bottom edge
    send_voxel(7'd127, 7'd127, 7'd127);
    settle();

    // z = 0, z negative, then zero truncation band.
    regs[CFG_ROW2_HI] = 64'd0;
    load_config();
    send_voxel(7'd0, 7'd0, 7'd0);
    settle();
    regs[CFG_ROW2_HI] = {32'hFFFF_0000, 32'h0000_0000};
    load_config();
    send_voxel(7'd0, 7'd0, 7'd0);
    settle();
    regs[CFG_ROW2_HI] = {32'h0001_0000, 32'h0000_0000};
    regs[CFG_TRUNC] = 64'd0;
    load_config();
    send_voxel(7'd0, 7'd0, 7'd0);             // depth 70000 > z: in front
    write_depth(19'd17, 32'd60000);
    send_voxel(7'd0, 7'd0, 7'd0);             // behind
    write_depth(19'd17, 32'd65536);
    send_voxel(7'd0, 7'd0, 7'd0);             // diff zero
    settle();

    // Random phases, each with its own pacing.
    hold_req = 1;
    random_config(1, {16'($urandom_range(8, 64)), 16'($urandom_range(8, 64))});
    random_traffic(150, 31);

    send_idle_pct = 80;
    random_config(1, {16'($urandom_range(8, 64)), 16'($urandom_range(8, 64))});
    random_traffic(150, 31);

    send_idle_pct = 0;
    recv_stall_pct = 80;
    random_config(1, {16'($urandom_range(8, 64)), 16'($urandom_range(8, 64))});
    random_traffic(150, 31);

    send_idle_pct = 25;
    recv_stall_pct = 25;
    random_config(1, {16'($urandom_range(8, 64)), 16'($urandom_range(8, 64))});
    random_traffic(150, 31);

    // Extreme coefficients, widest image, widest band.
    foreach (regs[n]) regs[n] = {extreme_word(), extreme_word()};
    regs[CFG_TRUNC] = 64'hFFFF_FFFF_FFFF_FFFF;
    regs[CFG_IMAGE] = 64'hFFFF_FFFF_FFFF_FFFF;
    load_config();
    random_traffic(150, 127);

    // Large image: neighbour addresses run past the store and wrap.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_config(30, 32'h0400_0400);
    random_traffic(150, 127);

    // Zero band after a random camera.
    recv_stall_pct = 80;
    random_config(1, {16'($urandom_range(8, 64)), 16'($urandom_range(8, 64))});
    regs[CFG_TRUNC] = 64'd0;
    load_config();
    random_traffic(150, 31);

    // Narrowest nonzero band.
    send_idle_pct = 80;
    recv_stall_pct = 0;
    random_config(1, {16'($urandom_range(8, 64)), 16'($urandom_range(8, 64))});
    regs[CFG_TRUNC] = 64'd1;
    load_config();
    random_traffic(150, 31);

    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("[tsdf_voxel_projection_core] OK");
    end else begin
      $display("[tsdf_voxel_projection_core] ERROR");
    end
    $finish;
  end

endmodule
